/* hw/rtl/u2f_rd_pkg.sv */
`timescale 1ns / 1ps

package u2f_rd_pkg;

  localparam int EcPointBytes   = 65;
  localparam int MaxLengthBytes = 4;
  localparam int QueueDepth     = 4;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_AUTH     = 2'd1;
  localparam logic [1:0] OP_VERSION  = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [2:0] TAG_PUBKEY  = 3'd0;
  localparam logic [2:0] TAG_KHANDLE = 3'd1;
  localparam logic [2:0] TAG_CERT    = 3'd2;
  localparam logic [2:0] TAG_SIG     = 3'd3;
  localparam logic [2:0] TAG_VERSION = 3'd4;
  localparam logic [2:0] TAG_SUMMARY = 3'd5;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_SHORT     = 2'd1;
  localparam logic [1:0] ERR_RESERVED  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       end_of_reply;
  } in_t;

  typedef struct packed {
    logic [2:0]  field_tag;
    logic [7:0]  data_byte;
    logic [11:0] field_offset;
    logic [15:0] status_word;
    logic [1:0]  error_code;
    logic [31:0] usage_counter;
    logic [7:0]  presence_byte;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic content_valid;
    logic summary_valid;
    out_t content;
    out_t summary;
  } push_t;

endpackage

/* hw/rtl/u2f_rd_parser.sv */
`timescale 1ns / 1ps

module u2f_rd_parser #(
  parameter int EC_POINT_BYTES   = u2f_rd_pkg::EcPointBytes,
  parameter int MAX_LENGTH_BYTES = u2f_rd_pkg::MaxLengthBytes
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              accept,
  input  u2f_rd_pkg::in_t   in_data,
  output u2f_rd_pkg::push_t push
);

  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_PUBKEY  = 4'd1;
  localparam logic [3:0] PH_KHLEN   = 4'd2;
  localparam logic [3:0] PH_KH      = 4'd3;
  localparam logic [3:0] PH_CTAG    = 4'd4;
  localparam logic [3:0] PH_CTAGX   = 4'd5;
  localparam logic [3:0] PH_CLEN    = 4'd6;
  localparam logic [3:0] PH_CLENX   = 4'd7;
  localparam logic [3:0] PH_CBODY   = 4'd8;
  localparam logic [3:0] PH_CINDEF  = 4'd9;
  localparam logic [3:0] PH_RSIG    = 4'd10;
  localparam logic [3:0] PH_CNT     = 4'd11;
  localparam logic [3:0] PH_ASIG    = 4'd12;
  localparam logic [3:0] PH_VERSION = 4'd13;
  localparam logic [3:0] PH_DEAD    = 4'd14;

  localparam logic [15:0] EC_LIMIT  = 16'(EC_POINT_BYTES);
  localparam logic [6:0]  LEN_LIMIT = 7'(MAX_LENGTH_BYTES);

  logic [1:0]  op_r;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  kh_len_r, kh_len_nxt;
  logic [31:0] cert_rem_r, cert_rem_nxt;
  logic [2:0]  len_left_r, len_left_nxt;
  logic        prior_zero_r, prior_zero_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [7:0]  pres_r, pres_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic [15:0] pos_inc;
  logic [6:0]  len_n;
  logic [31:0] cert_shift;
  logic [31:0] cert_dec;
  logic [2:0]  len_dec;
  logic [1:0]  fin_err;
  logic [15:0] status;
  logic        c_valid;
  logic [2:0]  c_tag;
  logic [11:0] c_off;

  assign b       = held0_r;
  assign pos_inc = (pos_r < 16'hFFFF) ? pos_r + 16'd1 : pos_r;
  assign len_n   = b[6:0];
  assign cert_shift = {cert_rem_r[23:0], b};
  assign cert_dec   = cert_rem_r - 32'd1;
  assign len_dec    = len_left_r - 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= u2f_rd_pkg::OP_REGISTER;
    end else if (cfg_we) begin
      op_r <= cfg_wdata;
    end
  end

  always_comb begin
    held0_nxt      = held0_r;
    held1_nxt      = held1_r;
    held_cnt_nxt   = held_cnt_r;
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    kh_len_nxt     = kh_len_r;
    cert_rem_nxt   = cert_rem_r;
    len_left_nxt   = len_left_r;
    prior_zero_nxt = prior_zero_r;
    cnt_nxt        = cnt_r;
    pres_nxt       = pres_r;
    err_nxt        = err_r;
    c_valid        = 1'b0;
    c_tag          = u2f_rd_pkg::TAG_PUBKEY;
    c_off          = (pos_r > 16'd4095) ? 12'd4095 : pos_r[11:0];
    fin_err        = u2f_rd_pkg::ERR_OK;
    status         = 16'd1;

    if (accept && held_cnt_r[1]) begin
      unique case (phase_r)
        PH_START: begin
          unique case (op_r)
            u2f_rd_pkg::OP_REGISTER: begin
              pos_nxt = '0;
              if (b != 8'd5) begin
                err_nxt   = u2f_rd_pkg::ERR_RESERVED;
                phase_nxt = PH_DEAD;
                pos_nxt   = pos_r;
              end else begin
                phase_nxt = PH_PUBKEY;
              end
            end
            u2f_rd_pkg::OP_AUTH: begin
              pres_nxt  = b;
              cnt_nxt   = '0;
              phase_nxt = PH_CNT;
              pos_nxt   = '0;
            end
            u2f_rd_pkg::OP_VERSION: begin
              phase_nxt = PH_VERSION;
              c_valid   = 1'b1;
              c_tag     = u2f_rd_pkg::TAG_VERSION;
              c_off     = '0;
              pos_nxt   = 16'd1;
            end
            default: begin
              phase_nxt = PH_DEAD;
            end
          endcase
        end
        PH_PUBKEY: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_PUBKEY;
          pos_nxt = pos_inc;
          if (pos_inc >= EC_LIMIT) begin
            phase_nxt = PH_KHLEN;
            pos_nxt   = '0;
          end
        end
        PH_KHLEN: begin
          kh_len_nxt = b;
          pos_nxt    = '0;
          phase_nxt  = (b != 8'd0) ? PH_KH : PH_CTAG;
        end
        PH_KH: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_KHANDLE;
          pos_nxt = pos_inc;
          if (pos_inc >= {8'd0, kh_len_r}) begin
            phase_nxt = PH_CTAG;
            pos_nxt   = '0;
          end
        end
        PH_CTAG: begin
          c_valid   = 1'b1;
          c_tag     = u2f_rd_pkg::TAG_CERT;
          pos_nxt   = pos_inc;
          phase_nxt = (b[4:0] == 5'd31) ? PH_CTAGX : PH_CLEN;
        end
        PH_CTAGX: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_CERT;
          pos_nxt = pos_inc;
          if (!b[7]) begin
            phase_nxt = PH_CLEN;
          end
        end
        PH_CLEN: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_CERT;
          pos_nxt = pos_inc;
          if (!b[7]) begin
            cert_rem_nxt = {24'd0, b};
            if (b != 8'd0) begin
              phase_nxt = PH_CBODY;
            end else begin
              phase_nxt = PH_RSIG;
              pos_nxt   = '0;
            end
          end else if (len_n == 7'd0) begin
            prior_zero_nxt = 1'b0;
            phase_nxt      = PH_CINDEF;
          end else if (len_n > LEN_LIMIT) begin
            err_nxt   = u2f_rd_pkg::ERR_TRUNCATED;
            phase_nxt = PH_DEAD;
          end else begin
            len_left_nxt = len_n[2:0];
            cert_rem_nxt = '0;
            phase_nxt    = PH_CLENX;
          end
        end
        PH_CLENX: begin
          c_valid      = 1'b1;
          c_tag        = u2f_rd_pkg::TAG_CERT;
          pos_nxt      = pos_inc;
          cert_rem_nxt = cert_shift;
          len_left_nxt = len_dec;
          if (len_dec == 3'd0) begin
            if (cert_shift != 32'd0) begin
              phase_nxt = PH_CBODY;
            end else begin
              phase_nxt = PH_RSIG;
              pos_nxt   = '0;
            end
          end
        end
        PH_CBODY: begin
          c_valid      = 1'b1;
          c_tag        = u2f_rd_pkg::TAG_CERT;
          pos_nxt      = pos_inc;
          cert_rem_nxt = cert_dec;
          if (cert_dec == 32'd0) begin
            phase_nxt = PH_RSIG;
            pos_nxt   = '0;
          end
        end
        PH_CINDEF: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_CERT;
          pos_nxt = pos_inc;
          if (b == 8'd0 && prior_zero_r) begin
            phase_nxt = PH_RSIG;
            pos_nxt   = '0;
          end else begin
            prior_zero_nxt = (b == 8'd0);
          end
        end
        PH_RSIG, PH_ASIG: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_SIG;
          pos_nxt = pos_inc;
        end
        PH_CNT: begin
          cnt_nxt = {cnt_r[23:0], b};
          pos_nxt = pos_r + 16'd1;
          if (pos_r + 16'd1 >= 16'd4) begin
            phase_nxt = PH_ASIG;
            pos_nxt   = '0;
          end
        end
        PH_VERSION: begin
          c_valid = 1'b1;
          c_tag   = u2f_rd_pkg::TAG_VERSION;
          pos_nxt = pos_inc;
        end
        default: begin
        end
      endcase
    end

    if (accept) begin
      if (held_cnt_r[1]) begin
        held0_nxt = held1_r;
        held1_nxt = in_data.reply_byte;
      end else if (held_cnt_r[0]) begin
        held1_nxt    = in_data.reply_byte;
        held_cnt_nxt = 2'd2;
      end else begin
        held0_nxt    = in_data.reply_byte;
        held_cnt_nxt = 2'd1;
      end
    end

    unique case (phase_nxt)
      PH_START: begin
        case (op_r)
          u2f_rd_pkg::OP_REGISTER: fin_err = u2f_rd_pkg::ERR_RESERVED;
          u2f_rd_pkg::OP_AUTH:     fin_err = u2f_rd_pkg::ERR_TRUNCATED;
          default:                 fin_err = u2f_rd_pkg::ERR_OK;
        endcase
      end
      PH_PUBKEY, PH_KHLEN, PH_KH, PH_CLENX, PH_CBODY, PH_CNT: begin
        fin_err = u2f_rd_pkg::ERR_TRUNCATED;
      end
      PH_DEAD: fin_err = err_nxt;
      default: fin_err = u2f_rd_pkg::ERR_OK;
    endcase

    if (held_cnt_r == 2'd0) begin
      fin_err = u2f_rd_pkg::ERR_SHORT;
      status  = 16'd1;
    end else begin
      status = {held0_nxt, held1_nxt};
    end

    push.content_valid           = accept && c_valid;
    push.content.field_tag       = c_tag;
    push.content.data_byte       = b;
    push.content.field_offset    = c_off;
    push.content.status_word     = '0;
    push.content.error_code      = u2f_rd_pkg::ERR_OK;
    push.content.usage_counter   = '0;
    push.content.presence_byte   = '0;
    push.content.last_result     = 1'b0;

    push.summary_valid           = accept && in_data.end_of_reply;
    push.summary.field_tag       = u2f_rd_pkg::TAG_SUMMARY;
    push.summary.data_byte       = '0;
    push.summary.field_offset    = '0;
    push.summary.status_word     = status;
    push.summary.error_code      = fin_err;
    push.summary.last_result     = 1'b1;
    if (fin_err == u2f_rd_pkg::ERR_OK && phase_nxt == PH_ASIG) begin
      push.summary.usage_counter = cnt_nxt;
      push.summary.presence_byte = pres_nxt;
    end else begin
      push.summary.usage_counter = '0;
      push.summary.presence_byte = '0;
    end

    if (accept && in_data.end_of_reply) begin
      held0_nxt      = '0;
      held1_nxt      = '0;
      held_cnt_nxt   = '0;
      phase_nxt      = PH_START;
      pos_nxt        = '0;
      kh_len_nxt     = '0;
      cert_rem_nxt   = '0;
      len_left_nxt   = '0;
      prior_zero_nxt = 1'b0;
      cnt_nxt        = '0;
      pres_nxt       = '0;
      err_nxt        = u2f_rd_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r      <= '0;
      held1_r      <= '0;
      held_cnt_r   <= '0;
      phase_r      <= PH_START;
      pos_r        <= '0;
      kh_len_r     <= '0;
      cert_rem_r   <= '0;
      len_left_r   <= '0;
      prior_zero_r <= 1'b0;
      cnt_r        <= '0;
      pres_r       <= '0;
      err_r        <= u2f_rd_pkg::ERR_OK;
    end else begin
      held0_r      <= held0_nxt;
      held1_r      <= held1_nxt;
      held_cnt_r   <= held_cnt_nxt;
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      kh_len_r     <= kh_len_nxt;
      cert_rem_r   <= cert_rem_nxt;
      len_left_r   <= len_left_nxt;
      prior_zero_r <= prior_zero_nxt;
      cnt_r        <= cnt_nxt;
      pres_r       <= pres_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

/* hw/rtl/u2f_rd_outq.sv */
`timescale 1ns / 1ps

module u2f_rd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  u2f_rd_pkg::push_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output u2f_rd_pkg::out_t  out_data
);

  localparam int Depth = u2f_rd_pkg::QueueDepth;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  u2f_rd_pkg::out_t ent_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_push;
  logic [AW-1:0] wr_ptr_p1;
  u2f_rd_pkg::out_t first_ent;
  u2f_rd_pkg::out_t second_ent;

  assign pop       = out_valid && out_ready;
  assign n_push    = 2'(push.content_valid) + 2'(push.summary_valid);
  assign wr_ptr_p1 = wr_ptr_r + AW'(1);
  assign first_ent  = push.content_valid ? push.content : push.summary;
  assign second_ent = push.summary;

  assign wr_ptr_nxt = wr_ptr_r + AW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign cnt_nxt    = cnt_r + CW'(n_push) - CW'(pop);

  assign room      = (cnt_r <= CW'(Depth - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      ent_r[wr_ptr_r] <= first_ent;
    end
    if (n_push == 2'd2) begin
      ent_r[wr_ptr_p1] <= second_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/u2f_reply_deframer_unit.sv */
`timescale 1ns / 1ps

// U2F reply deframer.
// Input channel (in_valid/in_ready/in_data): one reply byte per request, with
// end_of_reply set on the last byte (the second status byte).
// Output channel (out_valid/out_ready/out_data): tagged content bytes of the
// reply, then one summary request (last_result = 1) carrying status word,
// error code and, for authenticate replies, counter and presence byte.
// cfg_we/cfg_wdata write the operation (register, authenticate, version);
// write it only while no reply is in flight.
// Results: each is written into the result queue when the input byte that
// causes it is taken. The last two bytes seen are held back as status, so
// each content byte leaves when the byte two places later arrives.
// Throughput: one byte per cycle while in_ready is high; the final byte of a
// reply can yield two results, which go into a four-entry result queue.
// in_ready is high while that queue has two free entries; when the receiver
// stalls, the queue fills and in_ready drops until results are taken.
// Reset (rst_n low, synchronous) empties the queue, restarts the parser at
// the start of a reply and sets the operation to register.
module u2f_reply_deframer_unit #(
  parameter int EC_POINT_BYTES   = u2f_rd_pkg::EcPointBytes,
  parameter int MAX_LENGTH_BYTES = u2f_rd_pkg::MaxLengthBytes
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  u2f_rd_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output u2f_rd_pkg::out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata
);

  u2f_rd_pkg::push_t push;
  logic              accept;

  assign accept = in_valid && in_ready;

  u2f_rd_parser #(
    .EC_POINT_BYTES  (EC_POINT_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_data  (in_data),
    .push     (push)
  );

  u2f_rd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* hw/rtl/u2f_rd_checker.sv */
`timescale 1ns / 1ps

module u2f_rd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input u2f_rd_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  a_summary_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_result ==
                   (out_data.field_tag == u2f_rd_pkg::TAG_SUMMARY)))
    else $error("last_result and summary tag disagree");

  a_content_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |->
      out_data.status_word == '0 && out_data.error_code == u2f_rd_pkg::ERR_OK &&
      out_data.usage_counter == '0 && out_data.presence_byte == '0)
    else $error("content request carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |->
      out_data.data_byte == '0 && out_data.field_offset == '0 &&
      (out_data.error_code == u2f_rd_pkg::ERR_OK ||
       (out_data.usage_counter == '0 && out_data.presence_byte == '0)))
    else $error("summary request carries content fields");

endmodule

bind u2f_reply_deframer_unit u2f_rd_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

/* tb/u2f_reply_deframer_checker.sv */
`timescale 1ns / 1ps

module u2f_reply_deframer_checker
  import u2f_rd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_t        in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  output int         fail_count,
  output int         pending_results
);

  localparam logic [7:0] ReservedByte  = 8'h05;
  localparam logic [7:0] LenIndefinite = 8'h80;

  typedef enum logic [3:0] {
    PH_START, PH_PUBKEY, PH_KHLEN, PH_KH, PH_CTAG, PH_CTAGX, PH_CLEN, PH_CLENX,
    PH_CBODY, PH_CINDEF, PH_RSIG, PH_CNT, PH_ASIG, PH_VERSION, PH_DEAD
  } phase_t;

  logic [1:0]  op_reg;
  logic [7:0]  held [2];
  logic [1:0]  held_cnt;
  phase_t      phase;
  logic [15:0] field_pos;
  logic [7:0]  kh_len;
  logic [31:0] cert_left;
  logic [2:0]  len_left;
  logic        zero_seen;
  logic [31:0] counter;
  logic [7:0]  presence;
  logic [1:0]  dead_err;
  out_t        expected_q [$];
  int          errors = 0;

  task automatic clear_reply_state();
    held[0]   = '0;
    held[1]   = '0;
    held_cnt  = '0;
    phase     = PH_START;
    field_pos = '0;
    kh_len    = '0;
    cert_left = '0;
    len_left  = '0;
    zero_seen = 1'b0;
    counter   = '0;
    presence  = '0;
    dead_err  = ERR_OK;
  endtask

  task automatic enter_phase(input phase_t p);
    phase     = p;
    field_pos = '0;
  endtask

  task automatic emit_byte(input logic [2:0] tag, input logic [7:0] b);
    out_t r;
    r              = '0;
    r.field_tag    = tag;
    r.data_byte    = b;
    r.field_offset = (field_pos > 16'd4095) ? 12'hFFF : field_pos[11:0];
    expected_q.push_back(r);
    if (field_pos != 16'hFFFF) field_pos++;
  endtask

  task automatic parse_content(input logic [7:0] b);
    case (phase)
      PH_START: begin
        case (op_reg)
          OP_REGISTER: begin
            if (b != ReservedByte) begin
              dead_err = ERR_RESERVED;
              phase    = PH_DEAD;
            end else begin
              enter_phase(PH_PUBKEY);
            end
          end
          OP_AUTH: begin
            presence = b;
            counter  = '0;
            enter_phase(PH_CNT);
          end
          OP_VERSION: begin
            enter_phase(PH_VERSION);
            emit_byte(TAG_VERSION, b);
          end
          default: phase = PH_DEAD;
        endcase
      end
      PH_PUBKEY: begin
        emit_byte(TAG_PUBKEY, b);
        if (field_pos >= EcPointBytes) enter_phase(PH_KHLEN);
      end
      PH_KHLEN: begin
        kh_len = b;
        enter_phase((b != 0) ? PH_KH : PH_CTAG);
      end
      PH_KH: begin
        emit_byte(TAG_KHANDLE, b);
        if (field_pos >= kh_len) enter_phase(PH_CTAG);
      end
      PH_CTAG: begin
        emit_byte(TAG_CERT, b);
        phase = (b[4:0] == 5'h1F) ? PH_CTAGX : PH_CLEN;
      end
      PH_CTAGX: begin
        emit_byte(TAG_CERT, b);
        if (!b[7]) phase = PH_CLEN;
      end
      PH_CLEN: begin
        emit_byte(TAG_CERT, b);
        if (b < LenIndefinite) begin
          cert_left = 32'(b);
          if (b != 0) phase = PH_CBODY;
          else enter_phase(PH_RSIG);
        end else if (b == LenIndefinite) begin
          zero_seen = 1'b0;
          phase     = PH_CINDEF;
        end else if (b[6:0] > MaxLengthBytes) begin
          dead_err = ERR_TRUNCATED;
          phase    = PH_DEAD;
        end else begin
          len_left  = b[2:0];
          cert_left = '0;
          phase     = PH_CLENX;
        end
      end
      PH_CLENX: begin
        emit_byte(TAG_CERT, b);
        cert_left = {cert_left[23:0], b};
        len_left  = len_left - 3'd1;
        if (len_left == 0) begin
          if (cert_left != 0) phase = PH_CBODY;
          else enter_phase(PH_RSIG);
        end
      end
      PH_CBODY: begin
        emit_byte(TAG_CERT, b);
        cert_left--;
        if (cert_left == 0) enter_phase(PH_RSIG);
      end
      PH_CINDEF: begin
        emit_byte(TAG_CERT, b);
        if (b == 0 && zero_seen) enter_phase(PH_RSIG);
        else zero_seen = (b == 0);
      end
      PH_RSIG, PH_ASIG: emit_byte(TAG_SIG, b);
      PH_CNT: begin
        counter = {counter[23:0], b};
        field_pos++;
        if (field_pos >= 4) enter_phase(PH_ASIG);
      end
      PH_VERSION: emit_byte(TAG_VERSION, b);
      default: ;
    endcase
  endtask

  function automatic logic [1:0] end_error();
    case (phase)
      PH_START: begin
        case (op_reg)
          OP_REGISTER: return ERR_RESERVED;
          OP_AUTH:     return ERR_TRUNCATED;
          default:     return ERR_OK;
        endcase
      end
      PH_PUBKEY, PH_KHLEN, PH_KH, PH_CLENX, PH_CBODY, PH_CNT: return ERR_TRUNCATED;
      PH_DEAD: return dead_err;
      default: return ERR_OK;
    endcase
  endfunction

  task automatic take_byte(input in_t d);
    out_t s;
    if (held_cnt >= 2) begin
      parse_content(held[0]);
      held[0] = held[1];
      held[1] = d.reply_byte;
    end else begin
      held[held_cnt[0]] = d.reply_byte;
      held_cnt++;
    end
    if (d.end_of_reply) begin
      s             = '0;
      s.field_tag   = TAG_SUMMARY;
      s.last_result = 1'b1;
      if (held_cnt < 2) begin
        s.status_word = 16'd1;
        s.error_code  = ERR_SHORT;
      end else begin
        s.status_word = {held[0], held[1]};
        s.error_code  = end_error();
      end
      if (s.error_code == ERR_OK && phase == PH_ASIG) begin
        s.usage_counter = counter;
        s.presence_byte = presence;
      end
      expected_q.push_back(s);
      clear_reply_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      op_reg = OP_REGISTER;
      clear_reply_state();
      expected_q.delete();
    end else begin
      if (cfg_we) op_reg = cfg_wdata;
      // a result cannot leave in the cycle its request is taken, so compare before predicting
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: field_tag %0d data_byte 0x%0h",
                 out_data.field_tag, out_data.data_byte);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("field_tag", want.field_tag, out_data.field_tag);
          check_field("data_byte", want.data_byte, out_data.data_byte);
          check_field("field_offset", want.field_offset, out_data.field_offset);
          check_field("status_word", want.status_word, out_data.status_word);
          check_field("error_code", want.error_code, out_data.error_code);
          check_field("usage_counter", want.usage_counter, out_data.usage_counter);
          check_field("presence_byte", want.presence_byte, out_data.presence_byte);
          check_field("last_result", want.last_result, out_data.last_result);
        end
      end
      if (in_valid && in_ready) take_byte(in_data);
    end
    fail_count      <= errors;
    pending_results <= expected_q.size();
  end

endmodule

/* tb/u2f_reply_deframer_unit_test.sv */
`timescale 1ns / 1ps

module u2f_reply_deframer_unit_test;
  import u2f_rd_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 4;
  localparam int RandomItems = 600;

  localparam logic [7:0] ReservedByte  = 8'h05;
  localparam logic [7:0] LenIndefinite = 8'h80;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = OP_REGISTER;

  int fail_count;
  int pending_results;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;

  logic [7:0] reply_bytes [$];

  always #5 clk = ~clk;

  u2f_reply_deframer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  u2f_reply_deframer_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply_bytes.size(); i++) begin
      send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_operation(input logic [1:0] op);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= op;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_random(input int n);
    repeat (n) reply_bytes.push_back(8'($urandom));
  endtask

  task automatic add_cert();
    int         n;
    int         len;
    logic [7:0] b;
    if ($urandom_range(3) == 0) begin
      reply_bytes.push_back(8'($urandom) | 8'h1F);
      repeat ($urandom_range(2)) reply_bytes.push_back(8'($urandom) | 8'h80);
      reply_bytes.push_back(8'($urandom) & 8'h7F);
    end else begin
      b = 8'($urandom);
      if (b[4:0] == 5'h1F) b[0] = 1'b0;
      reply_bytes.push_back(b);
    end
    len = ($urandom_range(15) == 0) ? 127 : $urandom_range(12);
    case ($urandom_range(9))
      0, 1, 2: begin
        reply_bytes.push_back(8'(len));
        add_random(len);
      end
      3, 4, 5: begin
        reply_bytes.push_back(LenIndefinite);
        repeat (len) begin
          b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
          if (b == 8'h00 && reply_bytes[$] == 8'h00) b = 8'h01;
          reply_bytes.push_back(b);
        end
        reply_bytes.push_back(8'h00);
        reply_bytes.push_back(8'h00);
      end
      6, 7, 8: begin
        n = $urandom_range(MaxLengthBytes, 1);
        reply_bytes.push_back(LenIndefinite | 8'(n));
        for (int i = n - 1; i >= 0; i--) reply_bytes.push_back(8'(len >> (8 * i)));
        add_random(len);
      end
      default: begin
        // too many length bytes
        reply_bytes.push_back(LenIndefinite | 8'($urandom_range(127, MaxLengthBytes + 1)));
        add_random($urandom_range(4));
      end
    endcase
  endtask

  task automatic build_content(input logic [1:0] op);
    int khl;
    reply_bytes.delete();
    case (op)
      OP_REGISTER: begin
        reply_bytes.push_back(ReservedByte);
        add_random(EcPointBytes);
        khl = ($urandom_range(31) == 0) ? 255 : $urandom_range(8);
        reply_bytes.push_back(8'(khl));
        add_random(khl);
        add_cert();
        add_random($urandom_range(10));
      end
      OP_AUTH:    add_random(5 + $urandom_range(10));
      OP_VERSION: add_random($urandom_range(10));
      default:    add_random($urandom_range(6));
    endcase
  endtask

  task automatic finish_reply();
    int cut;
    if ($urandom_range(24) == 0) begin
      reply_bytes.delete();
      reply_bytes.push_back(8'($urandom));
      return;
    end
    if (reply_bytes.size() > 0 && $urandom_range(9) == 0) reply_bytes[0] = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(reply_bytes.size());
      while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
    end
    if ($urandom_range(1) == 0) begin
      reply_bytes.push_back(8'h90);
      reply_bytes.push_back(8'h00);
    end else begin
      add_random(2);
    end
  endtask

  initial begin
    int         phase_no;
    int         base;
    logic [1:0] op_pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reply_bytes = '{8'h6A};
    send_reply();
    reply_bytes = '{8'h90, 8'h00};
    send_reply();
    reply_bytes = '{8'h07, 8'hAA, 8'h90, 8'h00};
    send_reply();
    build_content(OP_REGISTER);
    reply_bytes.push_back(8'hFF);
    reply_bytes.push_back(8'hFF);
    send_reply();
    build_content(OP_REGISTER);
    while (reply_bytes.size() > 10) void'(reply_bytes.pop_back());
    reply_bytes.push_back(8'h90);
    reply_bytes.push_back(8'h00);
    send_reply();

    set_operation(OP_AUTH);
    reply_bytes = '{8'h90, 8'h00};
    send_reply();
    reply_bytes = '{8'h01, 8'h00, 8'h00, 8'h90, 8'h00};
    send_reply();
    reply_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h90, 8'h00};
    send_reply();

    set_operation(OP_VERSION);
    reply_bytes = '{8'h90, 8'h00};
    send_reply();

    set_operation(OP_NONE);
    reply_bytes = '{8'h12, 8'h34, 8'h90, 8'h00};
    send_reply();

    phase_no = 0;
    base     = items_sent;
    while (items_sent - base < RandomItems) begin
      if (phase_no < 4) op_pick = 2'(phase_no);
      else if ($urandom_range(7) == 0) op_pick = OP_NONE;
      else op_pick = 2'($urandom_range(2));
      set_operation(op_pick);
      case (phase_no % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      repeat ($urandom_range(8, 3)) begin
        build_content(op_pick);
        finish_reply();
        send_reply();
      end
      phase_no++;
    end

    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/u2f_rd_pkg.sv
hw/rtl/u2f_rd_parser.sv
hw/rtl/u2f_rd_outq.sv
hw/rtl/u2f_reply_deframer_unit.sv
hw/rtl/u2f_rd_checker.sv
tb/u2f_reply_deframer_checker.sv
tb/u2f_reply_deframer_unit_test.sv
